// ----- sv/tma_pkg.sv -----
// ----------------------------------------------------------------------------
// tma_pkg - shared types, constants and helpers
// Widths, step counts and small arithmetic helpers for the trajectory
// metric accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tma_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 63;

    // shared multiplier: 33 x 33 unsigned
    localparam int MUL_W  = SAMPLE_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // square root of a 66-bit sum of squares gives 33 bits
    localparam int ROOT_W     = PROD_W / 2;
    localparam int ROOT_REM_W = ROOT_W + 3;

    // trapezoid: (cur + prev) * dt / 2000, dividend 49 bits
    localparam int TRAP_DIV = 2000;
    localparam int QUOT_W   = MUL_W + DT_W;
    localparam int DREM_W   = 11;

    // divide by 2000 one 17-bit digit at a time: the partial dividend is the
    // running remainder followed by the next digit, and its quotient digit
    // comes from a reciprocal multiply on the shared multiplier. The shift is
    // the partial dividend width plus the divisor's bit length, which keeps
    // the reciprocal product exact for every partial dividend.
    localparam int DIGIT_W    = 17;
    localparam int DIV_DIGITS = 3;
    localparam int DVD_W      = DIGIT_W * DIV_DIGITS;
    localparam int DIV_V_W    = DREM_W + DIGIT_W;
    localparam int DIV_SHIFT  = DIV_V_W + DREM_W;
    localparam int DIG_CNT_W  = 2;
    localparam logic [MUL_W-1:0] DIV_RECIP =
        MUL_W'(((64'd1 << DIV_SHIFT) + 64'(TRAP_DIV) - 64'd1) / 64'(TRAP_DIV));
    localparam logic [DIG_CNT_W-1:0] DIV_LAST = DIG_CNT_W'(DIV_DIGITS - 1);

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(ROOT_W);

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_MUL_LAT,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_MUL_L,
        S_DIV_L,
        S_WAIT_L,
        S_MUL_T,
        S_DIV_T,
        S_WAIT_T,
        S_DONE
    } tma_state_t;

    // |a - b| of two signed samples
    function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] d;
        logic [SAMPLE_W:0] m;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        m = d[SAMPLE_W] ? (~d + 1'b1) : d;
        return m[SAMPLE_W-1:0];
    endfunction

    // magnitude of a signed sample, most negative value exact
    function automatic logic [SAMPLE_W-1:0] abs_val(input logic [SAMPLE_W-1:0] a);
        return a[SAMPLE_W-1] ? (~a + 1'b1) : a;
    endfunction

    // saturating add to a 63-bit total
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [SUM_W-1:0] inc);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + {1'b0, inc};
        return (s[SUM_W] || (s[SUM_W-1:0] == SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tma_ifs.sv -----
// ----------------------------------------------------------------------------
// tma_ifs - sample and result channel interfaces
// Valid/ready channels carrying one sample word and one totals word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tma_sample_if;
    logic                            valid;
    logic                            ready;
    logic [tma_pkg::SAMPLE_W-1:0]    pos_x;
    logic [tma_pkg::SAMPLE_W-1:0]    pos_y;
    logic [tma_pkg::SAMPLE_W-1:0]    pos_z;
    logic [tma_pkg::SAMPLE_W-1:0]    lin_velocity;
    logic [tma_pkg::SAMPLE_W-1:0]    yaw_rate;
    logic [tma_pkg::SAMPLE_W-1:0]    accel_fwd;
    logic [tma_pkg::DT_W-1:0]        delta_ms;

    modport source (output valid, pos_x, pos_y, pos_z, lin_velocity, yaw_rate,
                    accel_fwd, delta_ms, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, lin_velocity, yaw_rate,
                    accel_fwd, delta_ms, output ready);
endinterface

interface tma_result_if;
    logic                          valid;
    logic                          ready;
    logic [tma_pkg::TIME_W-1:0]    elapsed_ms;
    logic [tma_pkg::SUM_W-1:0]     path_length;
    logic [tma_pkg::SUM_W-1:0]     lateral_total;
    logic [tma_pkg::SUM_W-1:0]     tangential_total;

    modport source (output valid, elapsed_ms, path_length, lateral_total,
                    tangential_total, input ready);
    modport sink   (input valid, elapsed_ms, path_length, lateral_total,
                    tangential_total, output ready);
endinterface

`default_nettype wire

// ----- sv/tma_mul.sv -----
// ----------------------------------------------------------------------------
// tma_mul - shared multiplier
// Unsigned 33 x 33 multiply with a registered product, ready in the cycle after its operands.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_mul (
    input  wire logic                        clk,
    input  wire logic [tma_pkg::MUL_W-1:0]   a,
    input  wire logic [tma_pkg::MUL_W-1:0]   b,
    output logic      [tma_pkg::PROD_W-1:0]  prod
);
    import tma_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- sv/tma_sqrt.sv -----
// ----------------------------------------------------------------------------
// tma_sqrt - iterative integer square root
// Floor square root of a 66-bit radicand, two radicand bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tma_pkg::PROD_W-1:0]   radicand,
    output logic                              done,
    output logic      [tma_pkg::ROOT_W-1:0]   root
);
    import tma_pkg::*;

    logic [PROD_W-1:0]     rad_reg;
    logic [ROOT_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [ROOT_REM_W-1:0] rem_sh;
    logic [ROOT_REM_W-1:0] trial;
    logic                  fits;

    // one restoring step
    assign rem_sh = {rem_reg[ROOT_REM_W-3:0], rad_reg[PROD_W-1:PROD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_STEPS - 1'b1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[PROD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- sv/tma_div.sv -----
// ----------------------------------------------------------------------------
// tma_div - divide by the trapezoid constant
// Reciprocal multiplication on the shared multiplier, one 17-bit quotient
// digit per issue and collect phase, three digits for the 49-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module tma_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tma_pkg::QUOT_W-1:0]   dividend,
    input  wire logic [tma_pkg::PROD_W-1:0]   prod,
    output logic      [tma_pkg::MUL_W-1:0]    mul_a,
    output logic      [tma_pkg::MUL_W-1:0]    mul_b,
    output logic                              done,
    output logic      [tma_pkg::QUOT_W-1:0]   quotient
);
    import tma_pkg::*;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     quot_reg;
    logic [DREM_W-1:0]    rem_reg;
    logic [DIV_V_W-1:0]   part_reg;
    logic [DIG_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 phase_reg;
    logic                 done_reg;

    logic [DIV_V_W-1:0]   part;
    logic [DIGIT_W-1:0]   q_digit;
    logic [DIV_V_W-1:0]   q_ext;
    logic [DIV_V_W-1:0]   q_scaled;
    logic [DIV_V_W-1:0]   rem_full;

    // partial dividend: running remainder followed by the next digit
    assign part  = {rem_reg, dvd_reg[DVD_W-1 -: DIGIT_W]};
    assign mul_a = {{(MUL_W-DIV_V_W){1'b0}}, part};
    assign mul_b = DIV_RECIP;

    // quotient digit from the product, remainder by constant multiply
    assign q_digit  = prod[DIV_SHIFT +: DIGIT_W];
    assign q_ext    = {{(DIV_V_W-DIGIT_W){1'b0}}, q_digit};
    assign q_scaled = q_ext * DIV_V_W'(TRAP_DIV);
    assign rem_full = part_reg - q_scaled;

    // control: issue phase then collect phase for each digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (run_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {{(DVD_W-QUOT_W){1'b0}}, dividend};
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (run_reg && !phase_reg)
        begin
            part_reg <= part;
            dvd_reg  <= {dvd_reg[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_full[DREM_W-1:0];
            quot_reg <= {quot_reg[DVD_W-DIGIT_W-1:0], q_digit};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg[QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/trajectory_metric_accumulator.sv -----
// ----------------------------------------------------------------------------
// trajectory_metric_accumulator - path length and stress integrals
// Sequencer around a shared multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel, one word per odometry sample (Q15.16
//            position, velocity, yaw rate, acceleration, 16-bit delta_ms).
//   result : valid/ready channel, one word per sample with the four totals
//            after that sample's update.
//   After a sample word is taken, the sequencer runs four multiplier
//   passes and the square root start, 33 square root steps up to done,
//   then per trapezoid integral a multiply, a divider start and three
//   reciprocal digits up to done, and then loads the output register
//   that presents the result word. sample.ready is high only while the
//   sequencer is idle, so one word is in work at a time and a new word
//   is taken only once the sequencer is through with the last one.
//   A finished result sits in an output register; the next word is taken
//   while it waits. If the receiver stalls, the following result is held
//   in the sequencer until the output register frees.
//   Reset clears all totals and the previous position and stress values
//   to zero, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_metric_accumulator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tma_sample_if.sink  sample,
    tma_result_if.source result
);
    import tma_pkg::*;

    tma_state_t state_reg, state_next;

    // captured sample
    logic [SAMPLE_W-1:0] px_reg, py_reg, pz_reg, vel_reg, yaw_reg, acc_reg;
    logic [DT_W-1:0]     dt_reg;

    // state carried between samples
    logic [SAMPLE_W-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic [SAMPLE_W-1:0] last_lat_reg, last_amag_reg;
    logic [SUM_W-1:0]    path_sum_reg, lat_sum_reg, tan_sum_reg;
    logic [TIME_W-1:0]   time_sum_reg;

    logic [PROD_W-1:0]   sq_acc_reg;
    logic [SAMPLE_W-1:0] lat_reg;

    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [SUM_W-1:0]    out_path_reg, out_lat_reg, out_tan_reg;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [MUL_W-1:0]    div_mul_a, div_mul_b;
    logic [PROD_W-1:0]   prod;
    logic                root_go, root_done, div_go, div_done;
    logic [ROOT_W-1:0]   root;
    logic [QUOT_W-1:0]   quot;
    logic [SAMPLE_W-1:0] amag;
    logic [PROD_W-FRAC_BITS-1:0] lat_wide;
    logic [SAMPLE_W-1:0] lat_next;
    logic [TIME_W:0]     time_add;
    logic [TIME_W-1:0]   time_next;
    logic                accept, finish, out_take;

    tma_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    tma_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_go),
        .radicand (sq_acc_reg),
        .done     (root_done),
        .root     (root)
    );

    tma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (prod[QUOT_W-1:0]),
        .prod     (prod),
        .mul_a    (div_mul_a),
        .mul_b    (div_mul_b),
        .done     (div_done),
        .quotient (quot)
    );

    // derived values
    assign amag     = abs_val(acc_reg);
    assign lat_wide = prod[PROD_W-1:FRAC_BITS];
    assign lat_next = (|lat_wide[PROD_W-FRAC_BITS-1:SAMPLE_W]) ? '1
                                                               : lat_wide[SAMPLE_W-1:0];
    assign time_add  = {1'b0, time_sum_reg} + {{(TIME_W+1-DT_W){1'b0}}, dt_reg};
    assign time_next = time_add[TIME_W] ? TIME_MAX : time_add[TIME_W-1:0];

    assign accept   = sample.valid && sample.ready;
    assign out_take = result.valid && result.ready;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // sequencer: next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        root_go    = 1'b0;
        div_go     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                    state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                mul_a      = {1'b0, abs_diff(px_reg, last_x_reg)};
                mul_b      = mul_a;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                mul_a      = {1'b0, abs_diff(py_reg, last_y_reg)};
                mul_b      = mul_a;
                state_next = S_MUL_Z;
            end
            S_MUL_Z:
            begin
                mul_a      = {1'b0, abs_diff(pz_reg, last_z_reg)};
                mul_b      = mul_a;
                state_next = S_MUL_LAT;
            end
            S_MUL_LAT:
            begin
                mul_a      = {1'b0, abs_val(yaw_reg)};
                mul_b      = {1'b0, abs_val(vel_reg)};
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO:
            begin
                root_go    = 1'b1;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (root_done)
                    state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                mul_a      = {1'b0, lat_reg} + {1'b0, last_lat_reg};
                mul_b      = {{(MUL_W-DT_W){1'b0}}, dt_reg};
                state_next = S_DIV_L;
            end
            S_DIV_L:
            begin
                div_go     = 1'b1;
                state_next = S_WAIT_L;
            end
            S_WAIT_L:
            begin
                // divider borrows the multiplier
                mul_a = div_mul_a;
                mul_b = div_mul_b;
                if (div_done)
                    state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                mul_a      = {1'b0, amag} + {1'b0, last_amag_reg};
                mul_b      = {{(MUL_W-DT_W){1'b0}}, dt_reg};
                state_next = S_DIV_T;
            end
            S_DIV_T:
            begin
                div_go     = 1'b1;
                state_next = S_WAIT_T;
            end
            S_WAIT_T:
            begin
                mul_a = div_mul_a;
                mul_b = div_mul_b;
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            last_lat_reg  <= '0;
            last_amag_reg <= '0;
            path_sum_reg  <= '0;
            lat_sum_reg   <= '0;
            tan_sum_reg   <= '0;
            time_sum_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
            if (root_done)
                path_sum_reg <= sat_add(path_sum_reg, {{(SUM_W-ROOT_W){1'b0}}, root});
            if (div_done && (state_reg == S_WAIT_L))
                lat_sum_reg <= sat_add(lat_sum_reg, {{(SUM_W-QUOT_W){1'b0}}, quot});
            if (div_done && (state_reg == S_WAIT_T))
                tan_sum_reg <= sat_add(tan_sum_reg, {{(SUM_W-QUOT_W){1'b0}}, quot});
            if (finish)
            begin
                time_sum_reg  <= time_next;
                last_x_reg    <= px_reg;
                last_y_reg    <= py_reg;
                last_z_reg    <= pz_reg;
                last_lat_reg  <= lat_reg;
                last_amag_reg <= amag;
            end
        end
    end

    // sample capture, square sum and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg  <= sample.pos_x;
            py_reg  <= sample.pos_y;
            pz_reg  <= sample.pos_z;
            vel_reg <= sample.lin_velocity;
            yaw_reg <= sample.yaw_rate;
            acc_reg <= sample.accel_fwd;
            dt_reg  <= sample.delta_ms;
        end
        if (state_reg == S_MUL_Y)
            sq_acc_reg <= prod;
        else if ((state_reg == S_MUL_Z) || (state_reg == S_MUL_LAT))
            sq_acc_reg <= sq_acc_reg + prod;
        if (state_reg == S_ROOT_GO)
            lat_reg <= lat_next;
        if (finish)
        begin
            out_time_reg <= time_next;
            out_path_reg <= path_sum_reg;
            out_lat_reg  <= lat_sum_reg;
            out_tan_reg  <= tan_sum_reg;
        end
    end

    assign sample.ready            = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.elapsed_ms       = out_time_reg;
    assign result.path_length      = out_path_reg;
    assign result.lateral_total    = out_lat_reg;
    assign result.tangential_total = out_tan_reg;

endmodule

`default_nettype wire

// ----- dv/trajectory_metric_accumulator_test.sv -----
// ----------------------------------------------------------------------------
// trajectory_metric_accumulator_test - self-checking bench for the accumulator
// Drives sample words over the valid/ready channel, predicts the four totals
// for each word and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trajectory_metric_accumulator_test;
    import tma_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] px, py, pz, vel, yaw, acc;
        logic [15:0] dt;
    } sample_t;

    typedef struct packed {
        logic [31:0] elapsed;
        logic [62:0] path, lat, tan;
    } totals_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tma_sample_if sample ();
    tma_result_if result ();

    trajectory_metric_accumulator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [31:0] prev_x, prev_y, prev_z, prev_lat, prev_amag;
    logic [62:0] path_acc, lat_acc, tan_acc;
    logic [31:0] time_acc;

    totals_t expected_totals[$];
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_off = 1'b0;
    longint  cycle_count = 0;

    // ------------------------------------------------------------------
    // predictor helpers
    function automatic logic [32:0] mag(input logic [31:0] a);
        return a[31] ? {1'b0, ~a} + 33'd1 : {1'b0, a};
    endfunction

    function automatic logic [62:0] add_sat(input logic [62:0] s, input logic [63:0] inc);
        logic [64:0] t;
        t = {2'b0, s} + {1'b0, inc};
        return (t > 65'h7FFF_FFFF_FFFF_FFFF) ? 63'h7FFF_FFFF_FFFF_FFFF : t[62:0];
    endfunction

    function automatic logic [63:0] trap_step(input logic [31:0] cur, input logic [31:0] prv,
                                              input logic [15:0] dt);
        logic [63:0] q;
        q = (({32'b0, cur} + {32'b0, prv}) * {48'b0, dt}) / 64'd2000;
        return q;
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'b0, c} * {64'b0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    task automatic predict_totals(input sample_t s);
        logic [32:0]  dx, dy, dz;
        logic [127:0] sq;
        logic [127:0] prod;
        logic [31:0]  lat, amag;
        logic [32:0]  tsum;
        dx = ({s.px[31], s.px} - {prev_x[31], prev_x});
        dx = dx[32] ? ~dx + 33'd1 : dx;
        dy = ({s.py[31], s.py} - {prev_y[31], prev_y});
        dy = dy[32] ? ~dy + 33'd1 : dy;
        dz = ({s.pz[31], s.pz} - {prev_z[31], prev_z});
        dz = dz[32] ? ~dz + 33'd1 : dz;
        sq = {95'b0, dx} * {95'b0, dx} + {95'b0, dy} * {95'b0, dy}
           + {95'b0, dz} * {95'b0, dz};
        tsum = {1'b0, time_acc} + {17'b0, s.dt};
        time_acc = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        path_acc = add_sat(path_acc, root_floor(sq));
        prev_x = s.px; prev_y = s.py; prev_z = s.pz;
        prod = ({95'b0, mag(s.yaw)} * {95'b0, mag(s.vel)}) >> FRAC_BITS;
        lat = (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        lat_acc = add_sat(lat_acc, trap_step(lat, prev_lat, s.dt));
        prev_lat = lat;
        amag = 32'(mag(s.acc));
        tan_acc = add_sat(tan_acc, trap_step(amag, prev_amag, s.dt));
        prev_amag = amag;
        expected_totals.push_back({time_acc, path_acc, lat_acc, tan_acc});
    endtask

    // ------------------------------------------------------------------
    // send one word, predicting its totals on acceptance; valid stays up
    // for a following word and drops when the sender idles or drains
    task automatic send_word(input sample_t s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid        <= 1'b1;
        sample.pos_x        <= s.px;
        sample.pos_y        <= s.py;
        sample.pos_z        <= s.pz;
        sample.lin_velocity <= s.vel;
        sample.yaw_rate     <= s.yaw;
        sample.accel_fwd    <= s.acc;
        sample.delta_ms     <= s.dt;
        do
            @(posedge clk);
        while (!sample.ready);
        predict_totals(s);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(65536 * 8)) - 32'd262144;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.px = rand_field(); s.py = rand_field(); s.pz = rand_field();
        s.vel = rand_field(); s.yaw = rand_field(); s.acc = rand_field();
        case ($urandom_range(3))
            0: s.dt = 16'd0;
            1: s.dt = 16'hFFFF;
            default: s.dt = 16'($urandom);
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        sample.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_totals.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // result checker
    always @(posedge clk)
    begin
        totals_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("unexpected result word");
                fail_count++;
            end
            else
            begin
                e = expected_totals.pop_front();
                if (result.elapsed_ms !== e.elapsed)
                begin
                    $error("elapsed_ms exp %0d got %0d", e.elapsed, result.elapsed_ms);
                    fail_count++;
                end
                if (result.path_length !== e.path)
                begin
                    $error("path_length exp %0d got %0d", e.path, result.path_length);
                    fail_count++;
                end
                if (result.lateral_total !== e.lat)
                begin
                    $error("lateral_total exp %0d got %0d", e.lat, result.lateral_total);
                    fail_count++;
                end
                if (result.tangential_total !== e.tan)
                begin
                    $error("tangential_total exp %0d got %0d", e.tan, result.tangential_total);
                    fail_count++;
                end
            end
        end
    end

    // receiver ready
    always @(posedge clk)
    begin
        if (hold_off || !rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test tasks
    task automatic test_directed();
        sample_t s;
        s = '0; s.dt = 16'd10;
        send_word(s);
        s = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF};
        send_word(s);
        // most negative values, full swing from the opposite extreme
        s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 16'hFFFF};
        send_word(s);
        // zero time step still replaces stored stress
        s = '{32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0003_0000,
              32'hFFFF_0000, 16'd0};
        send_word(s);
        s = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'd1000};
        send_word(s);
        s = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h8000_0001, 32'h0000_0001, 16'h5555};
        send_word(s);
        s = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'hAAAA};
        send_word(s);
        wait_drained();
    endtask

    // repeated extreme words: full swing in x and y, the largest stress increments per word
    task automatic test_saturation();
        sample_t s;
        for (int i = 0; i < 20; i++)
        begin
            s = '{(i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                  (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF};
            send_word(s);
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_word(rand_sample());
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_word(rand_sample());
        join
        wait_drained();
    endtask

    initial
    begin
        sample.valid = 1'b0;
        sample.pos_x = '0; sample.pos_y = '0; sample.pos_z = '0;
        sample.lin_velocity = '0; sample.yaw_rate = '0; sample.accel_fwd = '0;
        sample.delta_ms = '0;
        prev_x = '0; prev_y = '0; prev_z = '0; prev_lat = '0; prev_amag = '0;
        path_acc = '0; lat_acc = '0; tan_acc = '0; time_acc = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 220);
        test_backpressure();
        test_random_phase(61, 0, 220);
        test_random_phase(0, 61, 220);
        test_random_phase(37, 37, 220);
        test_saturation();

        repeat (400) @(posedge clk);
        if (fail_count == 0 && expected_totals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
